// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define NBSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NBSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/nbsp_pkg.sv =====
// Package for the nine-bit word packer: widths, register map and
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package nbsp_pkg;

    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 9;
    localparam int ACC_W   = 16;
    localparam int CNT_W   = 5;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [0:0] REG_PAD_COMMAND = 1'b0;
    localparam logic [BYTE_W-1:0] PAD_COMMAND_RESET = 8'h00;

    typedef struct packed {
        logic load_word;
        logic load_pad;
        logic emit;
        logic last;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic rem_ge8;
        logic rem_zero;
    } stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/nbsp_if.sv =====
// Stream interfaces for input words and output bytes.
// Depends on nbsp_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface nbsp_word_if;
    logic                       valid;
    logic                       ready;
    logic [nbsp_pkg::BYTE_W-1:0] word_byte;
    logic                       is_data;
    logic                       flush_after;

    modport source (output valid, output word_byte, output is_data, output flush_after,
                    input ready);
    modport sink   (input valid, input word_byte, input is_data, input flush_after,
                    output ready);
endinterface

interface nbsp_byte_if;
    logic                       valid;
    logic                       ready;
    logic [nbsp_pkg::BYTE_W-1:0] out_byte;
    logic                       last_of_item;

    modport source (output valid, output out_byte, output last_of_item, input ready);
    modport sink   (input valid, input out_byte, input last_of_item, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/nbsp_ctrl.sv =====
// Controller state machine of the word packer: sequences word load,
// byte emission and padding. Depends on nbsp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nbsp_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic            flush_in,
    output logic                 in_ready,
    input  wire nbsp_pkg::stat_t stat,
    output nbsp_pkg::cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SHIFT = 3'b010,
        ST_PAD   = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   flush_reg, flush_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            flush_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            flush_reg <= flush_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        flush_next = flush_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_word = 1'b1;
                    flush_next    = flush_in;
                    state_next    = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.rem_ge8)
                    begin
                        state_next = ST_SHIFT;
                    end
                    else if (flush_reg && !stat.rem_zero)
                    begin
                        state_next = ST_PAD;
                    end
                    else
                    begin
                        cmd.last   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_PAD:
            begin
                cmd.load_pad = 1'b1;
                state_next   = ST_SHIFT;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/nbsp_dpath.sv =====
// Datapath of the word packer: left-aligned bit accumulator, bit count
// and output byte register. Depends on nbsp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nbsp_dpath (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire nbsp_pkg::cmd_t              cmd,
    output nbsp_pkg::stat_t                  stat,
    input  wire logic [nbsp_pkg::BYTE_W-1:0] word_byte,
    input  wire logic                        is_data,
    input  wire logic [nbsp_pkg::BYTE_W-1:0] pad_command,
    input  wire logic                        out_ready,
    output logic                             out_valid,
    output logic [nbsp_pkg::BYTE_W-1:0]      out_byte,
    output logic                             out_last
);

    localparam int ACC_W  = nbsp_pkg::ACC_W;
    localparam int CNT_W  = nbsp_pkg::CNT_W;
    localparam int BYTE_W = nbsp_pkg::BYTE_W;
    localparam int WORD_W = nbsp_pkg::WORD_W;

    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;
    logic [WORD_W-1:0] word9;
    logic [ACC_W-1:0]  append;

    assign word9  = cmd.load_pad ? {1'b0, pad_command} : {is_data, word_byte};
    assign append = {word9, {(ACC_W-WORD_W){1'b0}}} >> cnt_reg[2:0];

    assign stat.out_free = !out_valid_reg || out_ready;
    assign stat.rem_ge8  = cnt_reg >= CNT_W'(2 * BYTE_W);
    assign stat.rem_zero = cnt_reg == CNT_W'(BYTE_W);

    always_comb
    begin
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_word || cmd.load_pad)
        begin
            acc_next = acc_reg | append;
            cnt_next = cnt_reg + CNT_W'(WORD_W);
        end
        else if (cmd.emit)
        begin
            acc_next       = {acc_reg[ACC_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
            cnt_next       = cnt_reg - CNT_W'(BYTE_W);
            out_valid_next = 1'b1;
            out_byte_next  = acc_reg[ACC_W-1 -: BYTE_W];
            out_last_next  = cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/nine_bit_spi_word_packer_core.sv =====
// Top level of the nine-bit word packer: APB register, controller and datapath.
// Depends on nbsp_pkg, nbsp_if, nbsp_ctrl and nbsp_dpath.
//
// Each input word (D/C bit then byte, MSB first) is appended to a 16-bit
// accumulator, then every completed byte leaves through the output
// register at one per cycle while the output is not stalled and no
// padding word is being appended. A flush appends padding words, each
// followed by the bytes it completes, until no bit is pending: at most
// seven padding words, when a word leaves one pending bit (nine bytes).
// Appends and byte shifts share the single accumulator, so one word is
// packed at a time. The next word is taken once the item's last byte
// sits in the output register. pad_command is at byte address 0 and
// should be written only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module nine_bit_spi_word_packer_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [nbsp_pkg::PADDR_W-1:0] paddr,
    input  wire logic [nbsp_pkg::PDATA_W-1:0] pwdata,
    output logic      [nbsp_pkg::PDATA_W-1:0] prdata,
    output logic                              pready,
    nbsp_word_if.sink                         word_in,
    nbsp_byte_if.source                       byte_out
);

    logic [nbsp_pkg::BYTE_W-1:0] pad_command_reg, pad_command_next;
    logic                        wr_pad;
    nbsp_pkg::cmd_t              cmd;
    nbsp_pkg::stat_t             stat;

    assign pready = 1'b1;
    assign wr_pad = psel && penable && pwrite && pready
                    && (paddr[nbsp_pkg::PADDR_W-1] == nbsp_pkg::REG_PAD_COMMAND);

    assign pad_command_next = wr_pad ? pwdata[nbsp_pkg::BYTE_W-1:0] : pad_command_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_command_reg <= nbsp_pkg::PAD_COMMAND_RESET;
        end
        else
        begin
            pad_command_reg <= pad_command_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[nbsp_pkg::PADDR_W-1] == nbsp_pkg::REG_PAD_COMMAND)
        begin
            prdata[nbsp_pkg::BYTE_W-1:0] = pad_command_reg;
        end
    end

    nbsp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (word_in.valid),
        .flush_in (word_in.flush_after),
        .in_ready (word_in.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    nbsp_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .word_byte   (word_in.word_byte),
        .is_data     (word_in.is_data),
        .pad_command (pad_command_reg),
        .out_ready   (byte_out.ready),
        .out_valid   (byte_out.valid),
        .out_byte    (byte_out.out_byte),
        .out_last    (byte_out.last_of_item)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/nbsp_checker.sv =====
// Port-level checker for the nine-bit word packer, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module nbsp_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic       out_last,
    input wire logic       pready
);

    `NBSP_ASSERT_IMP(a_pready_high, clk, rst_n, 1'b1, pready, "pready dropped")
    `NBSP_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready,
                     "input taken while a transaction is in progress")
    `NBSP_ASSERT_IMP(a_idle_shows_last, clk, rst_n, in_ready && out_valid, out_last,
                     "idle with a non-final byte pending")
    `NBSP_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                     out_valid && $stable(out_byte) && $stable(out_last),
                     "stalled output transaction changed")

endmodule

bind nine_bit_spi_word_packer_core nbsp_checker u_nbsp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (word_in.valid),
    .in_ready  (word_in.ready),
    .out_valid (byte_out.valid),
    .out_ready (byte_out.ready),
    .out_byte  (byte_out.out_byte),
    .out_last  (byte_out.last_of_item),
    .pready    (pready)
);
`default_nettype wire
